// ===== hw/rtl/mm_pkg.sv =====
// ----------------------------------------------------------------------------
// mm_pkg: shared types and constants for the matrix multiplier
// Holds the sequencer state type, the MAC control group, the register codes
// and the fixed widths of the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

package mm_pkg;

	localparam int DIM_REG_W   = 4;
	localparam int PRODUCT_W   = 35;
	localparam int INDEX_W     = 3;
	localparam int OUT_TDATA_W = 48;
	localparam int CFG_ADDR_W  = 4;
	localparam int CFG_DATA_W  = 32;

	localparam logic [1:0] REG_ROWS_A    = 2'd0;
	localparam logic [1:0] REG_INNER_DIM = 2'd1;
	localparam logic [1:0] REG_COLS_B    = 2'd2;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

	// Control that travels with one product through the MAC pipeline.
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_ctl_t;

	// A register value of zero counts as one, anything above the limit as the limit.
	function automatic logic [DIM_REG_W-1:0] eff_dim(input logic [DIM_REG_W-1:0] r,
		input logic [DIM_REG_W-1:0] max_dim);
		logic [DIM_REG_W-1:0] v;
		v = r;
		if (r == '0) begin
			v = {{(DIM_REG_W-1){1'b0}}, 1'b1};
		end else if (r > max_dim) begin
			v = max_dim;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply: streaming dense integer matrix multiplier
// Loads A then B row-major into two RAMs and streams out C = A * B
// row-major, computed on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//  Channel   Dir  Contents
//  s_axis    in   tdata: element_value (A row-major, then B row-major)
//  m_axis    out  tdata: product_value, row_index, col_index; tlast: last_result
//  apb       in   registers rows_a @0x0, inner_dim @0x4, cols_b @0x8
//
//  Loading takes one element beat per cycle; s_axis_tready is high only then.
//  After the last B beat each result is formed on the MAC from inner_dim
//  products (one store read per product, then RAM, multiply and accumulate
//  stages); the next result is issued only once this one has been captured.
//  A result held in the output register stalls the sequencer until taken.
//  Reset restores all dimensions to 8 and starts a fresh load; store contents
//  are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply #(
	parameter int MAX_DIM      = 8,
	parameter int ELEMENT_BITS = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// tdata: element_value [ELEMENT_BITS-1:0], zero padded to whole bytes
	input  wire logic [((ELEMENT_BITS+7)/8)*8-1:0]     s_axis_tdata,
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	// tdata: product_value [34:0], row_index [37:35], col_index [40:38], zeros
	output logic [mm_pkg::OUT_TDATA_W-1:0]             m_axis_tdata,
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	output logic                                       m_axis_tlast,
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [mm_pkg::CFG_ADDR_W-1:0]         paddr,
	input  wire logic [mm_pkg::CFG_DATA_W-1:0]         pwdata,
	output logic [mm_pkg::CFG_DATA_W-1:0]              prdata,
	output logic                                       pready
);

	localparam int DIM_W  = $clog2(MAX_DIM);
	localparam int ADDR_W = 2 * DIM_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int ACC_W  = 2 * ELEMENT_BITS + DIM_W + 1;
	localparam int DR_W   = mm_pkg::DIM_REG_W;

	// Configuration registers.
	logic [DR_W-1:0] rows_a_q;
	logic [DR_W-1:0] inner_dim_q;
	logic [DR_W-1:0] cols_b_q;
	logic            cfg_wr;
	logic            cfg_known;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign cfg_known = (paddr[3:2] == mm_pkg::REG_ROWS_A) ||
		(paddr[3:2] == mm_pkg::REG_INNER_DIM) || (paddr[3:2] == mm_pkg::REG_COLS_B);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= DR_W'(8);
			inner_dim_q <= DR_W'(8);
			cols_b_q    <= DR_W'(8);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				mm_pkg::REG_ROWS_A:    rows_a_q    <= pwdata[DR_W-1:0];
				mm_pkg::REG_INNER_DIM: inner_dim_q <= pwdata[DR_W-1:0];
				mm_pkg::REG_COLS_B:    cols_b_q    <= pwdata[DR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			mm_pkg::REG_ROWS_A:    prdata = mm_pkg::CFG_DATA_W'(rows_a_q);
			mm_pkg::REG_INNER_DIM: prdata = mm_pkg::CFG_DATA_W'(inner_dim_q);
			mm_pkg::REG_COLS_B:    prdata = mm_pkg::CFG_DATA_W'(cols_b_q);
			default:               prdata = '0;
		endcase
	end

	// Dimension limits, as last index values.
	logic [DR_W-1:0]  ra_eff, id_eff, cb_eff;
	logic [DIM_W-1:0] ra_m1, id_m1, cb_m1;

	assign ra_eff = mm_pkg::eff_dim(rows_a_q, DR_W'(MAX_DIM));
	assign id_eff = mm_pkg::eff_dim(inner_dim_q, DR_W'(MAX_DIM));
	assign cb_eff = mm_pkg::eff_dim(cols_b_q, DR_W'(MAX_DIM));
	assign ra_m1  = DIM_W'(ra_eff - DR_W'(1));
	assign id_m1  = DIM_W'(id_eff - DR_W'(1));
	assign cb_m1  = DIM_W'(cb_eff - DR_W'(1));

	// Sequencer.
	mm_pkg::state_t state_q, state_d;
	logic           in_beat;
	logic           ld_phase_q;
	logic [DIM_W-1:0] ld_r_q, ld_c_q;
	logic [DIM_W-1:0] ld_r_lim, ld_c_lim;
	logic           ld_last_c, ld_last_r;
	logic [DIM_W-1:0] ci_q, cj_q, ck_q;
	logic           issue_last;
	logic           capture;
	logic           last_pair;
	logic           mac_done;
	logic signed [ACC_W-1:0] mac_sum;
	mm_pkg::mac_ctl_t mac_ctl;

	logic                    out_v_q;
	logic [mm_pkg::PRODUCT_W-1:0] out_prod_q;
	logic [mm_pkg::INDEX_W-1:0]   out_row_q, out_col_q;
	logic                    out_last_q;

	assign s_axis_tready = (state_q == mm_pkg::ST_LOAD);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign ld_r_lim      = ld_phase_q ? id_m1 : ra_m1;
	assign ld_c_lim      = ld_phase_q ? cb_m1 : id_m1;
	assign ld_last_c     = (ld_c_q == ld_c_lim);
	assign ld_last_r     = (ld_r_q == ld_r_lim);
	assign issue_last    = (ck_q == id_m1);
	assign last_pair     = (ci_q == ra_m1) && (cj_q == cb_m1);

	always_comb begin
		state_d = state_q;
		capture = 1'b0;
		mac_ctl = '0;
		unique case (state_q)
			mm_pkg::ST_LOAD: begin
				if (in_beat && ld_phase_q && ld_last_c && ld_last_r) begin
					state_d = mm_pkg::ST_ISSUE;
				end
			end
			mm_pkg::ST_ISSUE: begin
				mac_ctl.valid = 1'b1;
				mac_ctl.first = (ck_q == '0);
				mac_ctl.last  = issue_last;
				if (issue_last) begin
					state_d = mm_pkg::ST_DRAIN;
				end
			end
			mm_pkg::ST_DRAIN: begin
				if (mac_done && (!out_v_q || m_axis_tready)) begin
					capture = 1'b1;
					state_d = last_pair ? mm_pkg::ST_LOAD : mm_pkg::ST_ISSUE;
				end
			end
			default: state_d = mm_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mm_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Load position: row and column within A, then within B.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_phase_q <= 1'b0;
			ld_r_q     <= '0;
			ld_c_q     <= '0;
		end else if (cfg_wr && cfg_known) begin
			ld_phase_q <= 1'b0;
			ld_r_q     <= '0;
			ld_c_q     <= '0;
		end else if (in_beat) begin
			if (ld_last_c) begin
				ld_c_q <= '0;
				if (ld_last_r) begin
					ld_r_q     <= '0;
					ld_phase_q <= !ld_phase_q;
				end else begin
					ld_r_q <= ld_r_q + DIM_W'(1);
				end
			end else begin
				ld_c_q <= ld_c_q + DIM_W'(1);
			end
		end
	end

	// Compute position: result row i, column j, inner index k.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ci_q <= '0;
			cj_q <= '0;
			ck_q <= '0;
		end else begin
			if (mac_ctl.valid) begin
				ck_q <= issue_last ? '0 : ck_q + DIM_W'(1);
			end
			if (capture) begin
				if (last_pair) begin
					ci_q <= '0;
					cj_q <= '0;
				end else if (cj_q == cb_m1) begin
					cj_q <= '0;
					ci_q <= ci_q + DIM_W'(1);
				end else begin
					cj_q <= cj_q + DIM_W'(1);
				end
			end
		end
	end

	// Element stores, addressed {row, column}.
	logic [ELEMENT_BITS-1:0] a_rdata, b_rdata;
	logic [ADDR_W-1:0]       ld_addr;

	assign ld_addr = {ld_r_q, ld_c_q};

	mm_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(DEPTH)) u_a_store (
		.clk   (clk),
		.we    (in_beat && !ld_phase_q),
		.waddr (ld_addr),
		.wdata (s_axis_tdata[ELEMENT_BITS-1:0]),
		.raddr ({ci_q, ck_q}),
		.rdata (a_rdata)
	);

	mm_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(DEPTH)) u_b_store (
		.clk   (clk),
		.we    (in_beat && ld_phase_q),
		.waddr (ld_addr),
		.wdata (s_axis_tdata[ELEMENT_BITS-1:0]),
		.raddr ({ck_q, cj_q}),
		.rdata (b_rdata)
	);

	mm_mac #(.ELEMENT_BITS(ELEMENT_BITS), .MAX_DIM(MAX_DIM)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a_data ($signed(a_rdata)),
		.b_data ($signed(b_rdata)),
		.sum    (mac_sum),
		.done   (mac_done)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (capture) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			out_prod_q <= mm_pkg::PRODUCT_W'(mac_sum);
			out_row_q  <= mm_pkg::INDEX_W'(ci_q);
			out_col_q  <= mm_pkg::INDEX_W'(cj_q);
			out_last_q <= last_pair;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {
		(mm_pkg::OUT_TDATA_W - mm_pkg::PRODUCT_W - 2 * mm_pkg::INDEX_W)'(0),
		out_col_q, out_row_q, out_prod_q};

	// The final result of a matrix carries the last row and column.
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |->
		(out_row_q == mm_pkg::INDEX_W'(ra_m1) && out_col_q == mm_pkg::INDEX_W'(cb_m1)))
		else $error("final result beat not at the last row and column");

	// No element is loaded while products are still being formed.
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |-> (!mac_ctl.valid && ck_q == '0))
		else $error("element accepted while the MAC is busy");

	a_back_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(capture && last_pair) |=> (state_q == mm_pkg::ST_LOAD && ci_q == '0 && cj_q == '0))
		else $error("sequencer did not return to loading after the final result");

	a_load_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mm_pkg::ST_LOAD) |-> (ld_r_q <= ld_r_lim && ld_c_q <= ld_c_lim))
		else $error("load position outside the configured matrix");

endmodule

`default_nettype wire

// ===== hw/rtl/mm_ram.sv =====
// ----------------------------------------------------------------------------
// mm_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mm_mac.sv =====
// ----------------------------------------------------------------------------
// mm_mac: shared multiply-accumulate unit
// Takes operand control in the cycle the store reads are issued; the operands
// arrive in the next cycle from the registered RAM outputs. The sum is held and
// flagged done once the beat marked last has been accumulated.
// ----------------------------------------------------------------------------
`default_nettype none

module mm_mac #(
	parameter int ELEMENT_BITS = 16,
	parameter int MAX_DIM      = 8
) (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	input  wire mm_pkg::mac_ctl_t                             ctl,
	input  wire logic signed [ELEMENT_BITS-1:0]               a_data,
	input  wire logic signed [ELEMENT_BITS-1:0]               b_data,
	output logic signed [2*ELEMENT_BITS+$clog2(MAX_DIM):0]    sum,
	output logic                                              done
);

	localparam int PROD_W = 2 * ELEMENT_BITS;
	localparam int ACC_W  = 2 * ELEMENT_BITS + $clog2(MAX_DIM) + 1;

	mm_pkg::mac_ctl_t          ctl_s1;
	mm_pkg::mac_ctl_t          ctl_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			if (ctl.valid && ctl.first) begin
				done_q <= 1'b0;
			end else if (ctl_s2.valid && ctl_s2.last) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			prod_s2 <= a_data * b_data;
		end
		if (ctl_s2.valid) begin
			acc_q <= (ctl_s2.first ? ACC_W'(0) : acc_q) + ACC_W'(prod_s2);
		end
	end

	assign sum  = acc_q;
	assign done = done_q;

	// While a finished sum is held, nothing may be in flight behind it.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (!ctl_s1.valid && !ctl_s2.valid))
		else $error("mac: sum flagged done with products still in flight");

	a_first_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.valid && ctl.first) |=> !done_q)
		else $error("mac: done not cleared by a new first beat");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for matrix_multiply
// Streams A and B matrices into the multiplier under a spread of dimension
// settings. The settings include out-of-range register values, loads that a
// register write cuts short, and a write to an unused address. Each result
// beat is checked field by field against products worked out here from the
// same elements. Both stream sides idle at random in two patterns, then never.
// ----------------------------------------------------------------------------

module tb_top;

	localparam int MAX_DIM       = 8;
	localparam int ELEM_W        = 16;
	localparam int ITEM_TARGET   = 310;
	localparam int SETTLE_CYCLES = 24;
	localparam int CYCLE_LIMIT   = 400000;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [mm_pkg::PRODUCT_W-1:0] product;
		logic [mm_pkg::INDEX_W-1:0]   row;
		logic [mm_pkg::INDEX_W-1:0]   col;
		logic                         last;
	} product_t;

	// Mirrors the dimension registers and both element stores, and queues
	// the result matrix once the last B element of a load has been seen.
	class product_ledger;
		logic [mm_pkg::DIM_REG_W-1:0] rows_reg;
		logic [mm_pkg::DIM_REG_W-1:0] inner_reg;
		logic [mm_pkg::DIM_REG_W-1:0] cols_reg;
		logic signed [ELEM_W-1:0] a_mem [MAX_DIM*MAX_DIM];
		logic signed [ELEM_W-1:0] b_mem [MAX_DIM*MAX_DIM];
		int unsigned              loaded;
		product_t                 due_products [$];
		int unsigned              errors;

		function void clear();
			rows_reg  = 4'd8;
			inner_reg = 4'd8;
			cols_reg  = 4'd8;
			loaded    = 0;
			errors    = 0;
			due_products.delete();
			foreach (a_mem[n]) begin
				a_mem[n] = '0;
				b_mem[n] = '0;
			end
		endfunction

		function int unsigned dim(logic [mm_pkg::DIM_REG_W-1:0] r);
			if (r == 0) return 1;
			if (r > MAX_DIM) return MAX_DIM;
			return r;
		endfunction

		function int unsigned load_size();
			return dim(rows_reg) * dim(inner_reg) + dim(inner_reg) * dim(cols_reg);
		endfunction

		// Any write to a known register restarts the load.
		function void write_reg(logic [1:0] idx, logic [mm_pkg::DIM_REG_W-1:0] value);
			case (idx)
				mm_pkg::REG_ROWS_A:    rows_reg = value;
				mm_pkg::REG_INNER_DIM: inner_reg = value;
				mm_pkg::REG_COLS_B:    cols_reg = value;
				default:               return;
			endcase
			loaded = 0;
		endfunction

		function void take_element(logic signed [ELEM_W-1:0] v);
			int unsigned ra, id, cb, size_a, m;
			longint      acc;
			product_t    r;
			ra     = dim(rows_reg);
			id     = dim(inner_reg);
			cb     = dim(cols_reg);
			size_a = ra * id;
			if (loaded < size_a) begin
				a_mem[(loaded / id) * MAX_DIM + loaded % id] = v;
			end else begin
				m = loaded - size_a;
				b_mem[(m / cb) * MAX_DIM + m % cb] = v;
			end
			loaded++;
			if (loaded < size_a + id * cb) return;
			loaded = 0;
			for (int i = 0; i < ra; i++) begin
				for (int j = 0; j < cb; j++) begin
					acc = 0;
					for (int k = 0; k < id; k++) begin
						acc += longint'(a_mem[i * MAX_DIM + k]) * longint'(b_mem[k * MAX_DIM + j]);
					end
					r.product = acc[mm_pkg::PRODUCT_W-1:0];
					r.row     = i[mm_pkg::INDEX_W-1:0];
					r.col     = j[mm_pkg::INDEX_W-1:0];
					r.last    = (i + 1 == ra) && (j + 1 == cb);
					due_products.insert(due_products.size(), r);
				end
			end
		endfunction

		function void match_result(logic [mm_pkg::OUT_TDATA_W-1:0] data, logic last);
			product_t got, want;
			got.product = data[mm_pkg::PRODUCT_W-1:0];
			got.row     = data[mm_pkg::PRODUCT_W+mm_pkg::INDEX_W-1:mm_pkg::PRODUCT_W];
			got.col     = data[mm_pkg::PRODUCT_W+2*mm_pkg::INDEX_W-1:
				mm_pkg::PRODUCT_W+mm_pkg::INDEX_W];
			got.last    = last;
			if (due_products.size() == 0) begin
				$error("unexpected result beat: row %0d col %0d value %0d",
					got.row, got.col, $signed(got.product));
				errors++;
				return;
			end
			want = due_products.pop_front();
			if (got.product !== want.product) begin
				$error("product_value: expected %0d, actual %0d",
					$signed(want.product), $signed(got.product));
				errors++;
			end
			if (got.row !== want.row) begin
				$error("row_index: expected %0d, actual %0d", want.row, got.row);
				errors++;
			end
			if (got.col !== want.col) begin
				$error("col_index: expected %0d, actual %0d", want.col, got.col);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last_result: expected %0b, actual %0b", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic [ELEM_W-1:0]              s_axis_tdata;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [mm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	logic                           m_axis_tlast;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [mm_pkg::CFG_ADDR_W-1:0]  paddr;
	logic [mm_pkg::CFG_DATA_W-1:0]  pwdata;
	logic [mm_pkg::CFG_DATA_W-1:0]  prdata;
	logic                           pready;

	product_ledger ledger;
	int            gap_pct;
	int            stall_pct;
	int            elements_sent = 0;
	int            cycle_count = 0;

	matrix_multiply u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tlast (m_axis_tlast),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			ledger.match_result(m_axis_tdata, m_axis_tlast);
		end
		m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	function automatic logic [mm_pkg::DIM_REG_W-1:0] pick_dim();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return mm_pkg::DIM_REG_W'($urandom_range(MAX_DIM + 1, 15));
			2:       return mm_pkg::DIM_REG_W'(MAX_DIM);
			3:       return mm_pkg::DIM_REG_W'($urandom_range(1, MAX_DIM));
			default: return mm_pkg::DIM_REG_W'($urandom_range(1, 4));
		endcase
	endfunction

	function automatic logic [ELEM_W-1:0] pick_element();
		case ($urandom_range(0, 7))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return ELEM_W'($urandom_range(0, 15)) - ELEM_W'(8);
			default: return ELEM_W'($urandom);
		endcase
	endfunction

	// The valid line is only lowered when a gap is taken, so that back-to-back
	// beats never see a low and a high assigned in the same step.
	task automatic send_element(input logic [ELEM_W-1:0] v);
		while ($urandom_range(0, 99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		ledger.take_element(v);
		elements_sent++;
		if (elements_sent == ITEM_TARGET / 3) begin
			gap_pct   = 56;
			stall_pct = 14;
		end else if (elements_sent == 2 * ITEM_TARGET / 3) begin
			gap_pct   = 0;
			stall_pct = 0;
		end
	endtask

	// Wait until every queued product has come out and the MAC has had time
	// to finish, so that a register write never lands on work in progress.
	task automatic quiesce();
		s_axis_tvalid <= 1'b0;
		while (ledger.due_products.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx,
		input logic [mm_pkg::DIM_REG_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= ($urandom << mm_pkg::DIM_REG_W) | value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		ledger.write_reg(idx, value);
	endtask

	task automatic apb_idle();
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin
		logic [1:0] idx;
		ledger = new;
		ledger.clear();
		gap_pct       = 14;
		stall_pct     = 56;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero reads as one and fifteen as eight: A is 2 x 8, B is 8 x 1.
		apb_write(mm_pkg::REG_ROWS_A, 4'd2);
		apb_write(mm_pkg::REG_INNER_DIM, 4'd15);
		apb_write(mm_pkg::REG_COLS_B, 4'd0);
		apb_idle();
		repeat (5) send_element(pick_element());
		quiesce();
		apb_write(mm_pkg::REG_INNER_DIM, 4'd15);
		apb_idle();
		// Row 0 gives the largest positive sum, row 1 the most negative one.
		// A write to the unused address midway must not restart the load.
		for (int n = 0; n < 24; n++) begin
			if (n == 10) begin
				quiesce();
				apb_write(REG_UNUSED, 4'd5);
				apb_idle();
			end
			send_element((n >= 8 && n < 16) ? 16'h7FFF : 16'h8000);
		end

		// Widest result shape first: 8 x 1 times 1 x 8 gives all 64 indices.
		quiesce();
		apb_write(mm_pkg::REG_ROWS_A, 4'd8);
		apb_write(mm_pkg::REG_INNER_DIM, 4'd1);
		apb_write(mm_pkg::REG_COLS_B, 4'd9);
		apb_idle();
		repeat (ledger.load_size()) send_element(pick_element());

		while (elements_sent < ITEM_TARGET) begin
			quiesce();
			apb_write(mm_pkg::REG_ROWS_A, pick_dim());
			apb_write(mm_pkg::REG_INNER_DIM, pick_dim());
			apb_write(mm_pkg::REG_COLS_B, pick_dim());
			apb_idle();
			if ($urandom_range(0, 2) == 0 && ledger.load_size() > 1) begin
				repeat ($urandom_range(1, ledger.load_size() - 1)) send_element(pick_element());
				quiesce();
				case ($urandom_range(0, 2))
					0:       idx = mm_pkg::REG_ROWS_A;
					1:       idx = mm_pkg::REG_INNER_DIM;
					default: idx = mm_pkg::REG_COLS_B;
				endcase
				apb_write(idx, pick_dim());
				apb_idle();
			end
			repeat ($urandom_range(1, 3)) begin
				if (elements_sent < ITEM_TARGET) begin
					repeat (ledger.load_size()) send_element(pick_element());
				end
			end
		end

		quiesce();
		if (ledger.errors == 0 && ledger.due_products.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/mm_pkg.sv
hw/rtl/mm_ram.sv
hw/rtl/mm_mac.sv
hw/rtl/matrix_multiply.sv
tb/tb_top.sv
